// ===== rtl/masked_window_rank_filter_core_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef MASKED_WINDOW_RANK_FILTER_CORE_MACROS_SVH
`define MASKED_WINDOW_RANK_FILTER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define MWRF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define MWRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MWRF_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MWRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/mwrf_pkg.sv =====
`timescale 1ns / 1ps
package mwrf_pkg;

    localparam int MAX_WINDOW_DEF = 9;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int MAX_HEIGHT     = 4096;
    localparam int PIX_FIELD_W    = 16;
    localparam int CFG_DATA_W     = 64;
    localparam int MASK_BITS      = 81;
    localparam int BLEND_FULL     = 256;

    typedef struct packed {
        logic                   action;
        logic [PIX_FIELD_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_FIELD_W-1:0] pixel_out;
        logic                   frame_last;
    } out_item_t;

    typedef enum logic [2:0] {
        CFG_FILTER_MODE   = 3'd0,
        CFG_WINDOW_SIZE   = 3'd1,
        CFG_MASK_LOW      = 3'd2,
        CFG_MASK_HIGH     = 3'd3,
        CFG_RANK_POSITION = 3'd4,
        CFG_BLEND_AMOUNT  = 3'd5,
        CFG_IMAGE_WIDTH   = 3'd6,
        CFG_IMAGE_HEIGHT  = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_MIN      = 3'd0,
        MODE_MAX      = 3'd1,
        MODE_RANK     = 3'd2,
        MODE_MEDIAN   = 3'd3,
        MODE_MIDPOINT = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GATHER,
        ST_ORIG,
        ST_SETTLE,
        ST_SELECT,
        ST_BLEND,
        ST_OUT
    } state_t;

    // Mirror an index into 0..n-1: below zero reflects, at or past n reflects
    // about n-1/2, then clamp for planes smaller than the window.
    function automatic logic [12:0] mirror_idx(input logic signed [15:0] k,
                                               input logic signed [15:0] n);
        logic signed [15:0] m;
        m = k;
        if (m < 16'sd0) begin
            m = -m;
        end else if (m >= n) begin
            m = (n <<< 1) - 16'sd1 - m;
        end
        if (m < 16'sd0) begin
            m = 16'sd0;
        end
        if (m > n - 16'sd1) begin
            m = n - 16'sd1;
        end
        return m[12:0];
    endfunction

endpackage

// ===== rtl/mwrf_ram.sv =====
`timescale 1ns / 1ps
module mwrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/mwrf_sort_cell.sv =====
`timescale 1ns / 1ps
module mwrf_sort_cell #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  in_valid,
    input  logic [PIXEL_BITS-1:0] in_value,
    output logic                  out_valid,
    output logic [PIXEL_BITS-1:0] out_value,
    output logic [PIXEL_BITS-1:0] held_value
);
    logic held_valid_reg;
    logic keep_in;

    // Keep the smaller of held and incoming; the larger moves right
    assign keep_in = !held_valid_reg || (in_value < held_value);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            held_valid_reg <= 1'b0;
            out_valid      <= 1'b0;
        end else begin
            out_valid <= in_valid && held_valid_reg;
            if (in_valid) begin
                held_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            if (keep_in) begin
                held_value <= in_value;
                out_value  <= held_value;
            end else begin
                out_value  <= in_value;
            end
        end
    end
endmodule

// ===== rtl/mwrf_sort_chain.sv =====
`timescale 1ns / 1ps
`include "masked_window_rank_filter_core_macros.svh"
module mwrf_sort_chain #(
    parameter int CELLS      = 81,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             clear,
    input  logic                             in_valid,
    input  logic [PIXEL_BITS-1:0]            in_value,
    output logic [CELLS-1:0][PIXEL_BITS-1:0] values
);
    logic [CELLS:0]                  link_valid;
    logic [CELLS:0][PIXEL_BITS-1:0]  link_value;

    assign link_valid[0] = in_valid;
    assign link_value[0] = in_value;

    // Systolic insertion sorter: ascending from cell 0
    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        mwrf_sort_cell #(
            .PIXEL_BITS(PIXEL_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .clear      (clear),
            .in_valid   (link_valid[c]),
            .in_value   (link_value[c]),
            .out_valid  (link_valid[c+1]),
            .out_value  (link_value[c+1]),
            .held_value (values[c])
        );
    end

    // At most CELLS values go in per window, so nothing falls off the end
    `MWRF_ASSERT_NOW(a_no_overflow, aclk, aresetn, 1'b1, !link_valid[CELLS])
    // A cleared chain passes nothing on the next cycle
    `MWRF_ASSERT_NEXT(a_clear_quiet, aclk, aresetn, clear, link_valid[CELLS:1] == '0)
    // Every value entering the chain is a known pixel
    `MWRF_ASSERT_NOW(a_in_known, aclk, aresetn, in_valid, !$isunknown(in_value))
endmodule

// ===== rtl/masked_window_rank_filter_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    in_item_t  (action, pixel_in)
// m_        out  m_valid/m_ready    out_item_t (pixel_out, frame_last)
// cfg_      in   cfg_we             cfg_index, cfg_data
//
// An item that yields no result goes from the check state straight back to
// idle. With a result, the window is read from the single line store read
// port one position a cycle, then the sorting chain settles one cell a cycle.
// The next item is taken once the result sits in the output register; a
// stalled m_ready holds the block before it loads.
// Reset is synchronous on aresetn and clears configuration, counters and control only.
`include "masked_window_rank_filter_core_macros.svh"
module masked_window_rank_filter_core #(
    parameter int MAX_WINDOW = mwrf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = mwrf_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mwrf_pkg::PIXEL_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mwrf_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mwrf_pkg::out_item_t               m_data,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [mwrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mwrf_pkg::*;

    localparam int WIN_CELLS = MAX_WINDOW * MAX_WINDOW;
    localparam int DEPTH     = MAX_WINDOW * MAX_WIDTH;
    localparam int AW        = $clog2(DEPTH);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = $clog2(MAX_WINDOW);
    localparam int CNT_W     = $clog2(WIN_CELLS + 1);
    localparam int IDX_W     = $clog2(WIN_CELLS);
    localparam int SET_W     = $clog2(WIN_CELLS + 1);
    localparam int PROD_W    = PIXEL_BITS + 11;
    localparam int SUM_W     = PIXEL_BITS + 12;

    // Configuration registers
    logic [2:0]  filter_mode_reg;
    logic [3:0]  window_size_reg;
    logic [63:0] mask_low_reg;
    logic [16:0] mask_high_reg;
    logic [6:0]  rank_position_reg;
    logic [8:0]  blend_amount_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic        geom_write;

    assign geom_write = cfg_we && (cfg_idx_t'(cfg_index) == CFG_WINDOW_SIZE ||
                                   cfg_idx_t'(cfg_index) == CFG_IMAGE_WIDTH ||
                                   cfg_idx_t'(cfg_index) == CFG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg   <= 3'd0;
            window_size_reg   <= 4'd3;
            mask_low_reg      <= 64'd511;
            mask_high_reg     <= 17'd0;
            rank_position_reg <= 7'd0;
            blend_amount_reg  <= 9'd256;
            image_width_reg   <= 13'd640;
            image_height_reg  <= 13'd480;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FILTER_MODE:   filter_mode_reg   <= cfg_data[2:0];
                CFG_WINDOW_SIZE:   window_size_reg   <= cfg_data[3:0];
                CFG_MASK_LOW:      mask_low_reg      <= cfg_data;
                CFG_MASK_HIGH:     mask_high_reg     <= cfg_data[16:0];
                CFG_RANK_POSITION: rank_position_reg <= cfg_data[6:0];
                CFG_BLEND_AMOUNT:  blend_amount_reg  <= cfg_data[8:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[12:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Effective geometry
    logic [14:0] w_eff;
    logic [14:0] h_eff;
    logic [3:0]  ws_c;
    logic [2:0]  rad;
    logic [3:0]  side;
    logic [8:0]  blend_c;

    always_comb begin
        if (image_width_reg == 13'd0) begin
            w_eff = 15'd1;
        end else if (15'(image_width_reg) > 15'(MAX_WIDTH)) begin
            w_eff = 15'(MAX_WIDTH);
        end else begin
            w_eff = 15'(image_width_reg);
        end
        if (image_height_reg == 13'd0) begin
            h_eff = 15'd1;
        end else if (15'(image_height_reg) > 15'(MAX_HEIGHT)) begin
            h_eff = 15'(MAX_HEIGHT);
        end else begin
            h_eff = 15'(image_height_reg);
        end
        ws_c = (32'(window_size_reg) > MAX_WINDOW) ? 4'(MAX_WINDOW) : window_size_reg;
        rad  = (ws_c == 4'd0) ? 3'd0 : 3'((ws_c - 4'd1) >> 1);
        side = {rad, 1'b1};
        blend_c = (blend_amount_reg > 9'(BLEND_FULL)) ? 9'(BLEND_FULL) : blend_amount_reg;
    end

    // Control and counters
    state_t state_reg, state_next;

    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic [12:0]       in_row_reg;
    logic [11:0]       out_row_reg;
    logic [SLOT_W-1:0] in_slot_reg, out_slot_reg;
    logic [3:0]        gj_reg, gi_reg;
    logic [6:0]        gp_reg;
    logic [SET_W-1:0]  settle_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rd_win_reg, rd_mask_reg, rd_orig_reg;
    logic [PIXEL_BITS-1:0] orig_reg, f_reg;
    logic              empty_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic s_fire, do_write, fire, gather_end, out_load, last;
    logic [14:0] ry, cx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign do_write = s_fire && !s_data.action && (15'(in_row_reg) < h_eff);

    // Result check: the lower-right pixel of the window has arrived
    always_comb begin
        ry = 15'(out_row_reg) + 15'(rad);
        if (ry > h_eff - 15'd1) begin
            ry = h_eff - 15'd1;
        end
        cx = 15'(out_col_reg) + 15'(rad);
        if (cx > w_eff - 15'd1) begin
            cx = w_eff - 15'd1;
        end
        fire = (15'(in_row_reg) > ry) ||
               ((15'(in_row_reg) == ry) && (15'(in_col_reg) > cx));
    end

    assign gather_end = (gj_reg == side - 4'd1) && (gi_reg == side - 4'd1);
    assign out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign last       = (15'(out_col_reg) == w_eff - 15'd1) &&
                        (15'(out_row_reg) == h_eff - 15'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_CHECK;
            ST_CHECK:  state_next = fire ? ST_GATHER : ST_IDLE;
            ST_GATHER: if (gather_end) state_next = ST_ORIG;
            ST_ORIG:   state_next = ST_SETTLE;
            ST_SETTLE: if (settle_reg == SET_W'(WIN_CELLS)) state_next = ST_SELECT;
            ST_SELECT: state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Input and output position counters
    always_ff @(posedge aclk) begin
        if (!aresetn || geom_write) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end else begin
            if (do_write) begin
                if (15'(in_col_reg) + 15'd1 >= w_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 13'd1;
                    in_slot_reg <= (32'(in_slot_reg) == MAX_WINDOW - 1) ? '0
                                   : in_slot_reg + SLOT_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            if (out_load) begin
                if (last) begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                end else if (15'(out_col_reg) + 15'd1 >= w_eff) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 12'd1;
                    out_slot_reg <= (32'(out_slot_reg) == MAX_WINDOW - 1) ? '0
                                    : out_slot_reg + SLOT_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Window read address: mirrored row and column, row mapped to its ring slot
    logic signed [15:0] kr, kc, dr, slot_s;
    logic [12:0]        yy, xx;
    logic [AW-1:0]      win_addr, orig_addr, rd_addr, wr_addr;

    always_comb begin
        kr = 16'(out_row_reg) + 16'(gj_reg) - 16'(rad);
        kc = 16'(out_col_reg) + 16'(gi_reg) - 16'(rad);
        yy = mirror_idx(kr, 16'(h_eff));
        xx = mirror_idx(kc, 16'(w_eff));
        dr = 16'(yy) - 16'(out_row_reg);
        slot_s = 16'(out_slot_reg) + dr;
        if (slot_s < 16'sd0) begin
            slot_s = slot_s + 16'(MAX_WINDOW);
        end else if (slot_s >= 16'(MAX_WINDOW)) begin
            slot_s = slot_s - 16'(MAX_WINDOW);
        end
        win_addr  = AW'(32'(slot_s[SLOT_W-1:0]) * MAX_WIDTH + 32'(xx));
        orig_addr = AW'(32'(out_slot_reg) * MAX_WIDTH + 32'(out_col_reg));
        wr_addr   = AW'(32'(in_slot_reg) * MAX_WIDTH + 32'(in_col_reg));
        rd_addr   = (state_reg == ST_ORIG) ? orig_addr : win_addr;
    end

    logic [PIXEL_BITS-1:0] ram_rdata;

    mwrf_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (wr_addr),
        .wdata (s_data.pixel_in[PIXEL_BITS-1:0]),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Gather sequencing and read pipeline flags
    logic [MASK_BITS-1:0] mask_vec;
    assign mask_vec = {mask_high_reg, mask_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gj_reg      <= '0;
            gi_reg      <= '0;
            gp_reg      <= '0;
            settle_reg  <= '0;
            cnt_reg     <= '0;
            rd_win_reg  <= 1'b0;
            rd_mask_reg <= 1'b0;
            rd_orig_reg <= 1'b0;
        end else begin
            rd_win_reg  <= (state_reg == ST_GATHER);
            rd_mask_reg <= (state_reg == ST_GATHER) && mask_vec[gp_reg];
            rd_orig_reg <= (state_reg == ST_ORIG);
            if (state_reg == ST_CHECK) begin
                gj_reg     <= '0;
                gi_reg     <= '0;
                gp_reg     <= '0;
                settle_reg <= '0;
                cnt_reg    <= '0;
            end
            if (state_reg == ST_GATHER) begin
                gp_reg <= gp_reg + 7'd1;
                if (gi_reg == side - 4'd1) begin
                    gi_reg <= '0;
                    gj_reg <= gj_reg + 4'd1;
                end else begin
                    gi_reg <= gi_reg + 4'd1;
                end
            end
            if (state_reg == ST_SETTLE) begin
                settle_reg <= settle_reg + SET_W'(1);
            end
            if (rd_win_reg && rd_mask_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_orig_reg) begin
            orig_reg <= ram_rdata;
        end
    end

    // Sorting chain
    logic [WIN_CELLS-1:0][PIXEL_BITS-1:0] sorted;

    mwrf_sort_chain #(
        .CELLS      (WIN_CELLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (state_reg == ST_CHECK),
        .in_valid (rd_win_reg && rd_mask_reg),
        .in_value (ram_rdata),
        .values   (sorted)
    );

    // Pick the filtered value from the sorted chain: one variable tap plus the head
    logic [IDX_W-1:0]      hi_idx, rank_idx, pick_idx;
    logic [CNT_W-1:0]      k_sel;
    logic [PIXEL_BITS-1:0] v_lo, v_pick, f_sel;
    logic [PIXEL_BITS:0]   mid_sum;

    always_comb begin
        hi_idx = (cnt_reg == '0) ? '0 : IDX_W'(cnt_reg - CNT_W'(1));
        if (mode_t'(filter_mode_reg) == MODE_MEDIAN) begin
            k_sel = cnt_reg >> 1;
        end else if (32'(rank_position_reg) > 32'(hi_idx)) begin
            k_sel = CNT_W'(hi_idx);
        end else begin
            k_sel = CNT_W'(rank_position_reg);
        end
        if (k_sel > CNT_W'(hi_idx)) begin
            k_sel = CNT_W'(hi_idx);
        end
        rank_idx = IDX_W'(k_sel);
        case (mode_t'(filter_mode_reg)) inside
            MODE_MAX, MODE_MIDPOINT: pick_idx = hi_idx;
            MODE_RANK, MODE_MEDIAN:  pick_idx = rank_idx;
            default:                 pick_idx = '0;
        endcase
        v_lo    = sorted[0];
        v_pick  = sorted[pick_idx];
        mid_sum = {1'b0, v_lo} + {1'b0, v_pick};
        if (mode_t'(filter_mode_reg) == MODE_MIDPOINT) begin
            f_sel = mid_sum[PIXEL_BITS:1];
        end else begin
            f_sel = v_pick;
        end
    end

    // Blend: orig + a*(f - orig)/256, rounded
    logic signed [PIXEL_BITS:0] diff;
    logic signed [SUM_W-1:0]    blend_sum;
    logic [PIXEL_BITS-1:0]      res;

    assign diff      = $signed({1'b0, f_reg}) - $signed({1'b0, orig_reg});
    assign blend_sum = $signed(SUM_W'({orig_reg, 8'd0})) + SUM_W'(prod_reg)
                       + SUM_W'(128);
    assign res       = empty_reg ? '0 : blend_sum[PIXEL_BITS+7:8];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SELECT) begin
            f_reg     <= f_sel;
            empty_reg <= (cnt_reg == '0);
        end
        if (state_reg == ST_BLEND) begin
            prod_reg <= $signed({1'b0, blend_c}) * diff;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.pixel_out  <= PIX_FIELD_W'(res);
            m_data_reg.frame_last <= last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The input never runs past the plane
    `MWRF_ASSERT_NOW(a_in_row_bound, aclk, aresetn, 1'b1, 15'(in_row_reg) <= h_eff)
    // No more values are counted than the window holds
    `MWRF_ASSERT_NOW(a_cnt_bound, aclk, aresetn, state_reg == ST_SELECT,
        32'(cnt_reg) <= 32'(side) * 32'(side))
    // The last pixel of a plane restarts all counters
    `MWRF_ASSERT_NEXT(a_plane_restart, aclk, aresetn, out_load && last,
        out_row_reg == '0 && out_col_reg == '0 && in_row_reg == '0)
    // Gather row pointer stays inside the window
    `MWRF_ASSERT_NOW(a_gather_bound, aclk, aresetn, state_reg == ST_GATHER, gj_reg < side)
endmodule
